FILE: rtl/core/icv_pkg.sv
`default_nettype none

package icv_pkg;

  // field widths
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned OFF_W      = 10;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // fixed point formats
  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned GAIN_FRAC_BITS = 14;
  localparam int unsigned SH_ACC         = 32 - FRAC_BITS;
  localparam int unsigned SH_MAG         = 32 + GAIN_FRAC_BITS - FRAC_BITS;

  // serial multiplier geometry: multiplier one bit per cycle, multiplicand parallel
  localparam int unsigned MUL_W  = WORD_W + 1;
  localparam int unsigned MC_W   = 48;
  localparam int unsigned PROD_W = MC_W + 1 + MUL_W;
  localparam int unsigned CNT_W  = $clog2(MUL_W);

  // scale factors, f * 2^32 rounded
  localparam longint unsigned TWO32  = 64'd4294967296;
  localparam longint unsigned PI_Q32 = 64'd13493037705;
  localparam longint unsigned ACC_K0 = (64'd610 * TWO32 + 64'd5000000) / 64'd10000000;
  localparam longint unsigned ACC_K1 = (64'd12207 * TWO32 + 64'd50000000) / 64'd100000000;
  localparam longint unsigned ACC_K2 = (64'd2441 * TWO32 + 64'd5000000) / 64'd10000000;
  localparam longint unsigned ACC_K3 = (64'd48828 * TWO32 + 64'd50000000) / 64'd100000000;
  localparam longint unsigned GYR_K0 = (64'd763 * PI_Q32 + 64'd9000000) / 64'd18000000;
  localparam longint unsigned GYR_K1 = (64'd1527 * PI_Q32 + 64'd9000000) / 64'd18000000;
  localparam longint unsigned GYR_K2 = (64'd3049 * PI_Q32 + 64'd9000000) / 64'd18000000;
  localparam longint unsigned GYR_K3 = (64'd6097 * PI_Q32 + 64'd9000000) / 64'd18000000;
  localparam longint unsigned MAG_K15 = (64'd15 * TWO32 + 64'd50) / 64'd100;

  // reset values
  localparam logic [WORD_W-1:0] CAL_MAX_RST = 16'h8000;
  localparam logic [WORD_W-1:0] CAL_MIN_RST = 16'h7fff;
  localparam logic [OFF_W-1:0]  MAG_OFF_X_RST  = 10'd26;
  localparam logic [OFF_W-1:0]  MAG_OFF_Y_RST  = 10'd14;
  localparam logic [OFF_W-1:0]  MAG_OFF_Z_RST  = 10'd35;
  localparam logic [GAIN_W-1:0] MAG_GAIN_X_RST = 16'd18907;
  localparam logic [GAIN_W-1:0] MAG_GAIN_Y_RST = 16'd19169;
  localparam logic [GAIN_W-1:0] MAG_GAIN_Z_RST = 16'd18022;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  typedef enum logic [1:0] {
    MODE_CONVERT = 2'd0,
    MODE_SAMPLE  = 2'd1,
    MODE_FINISH  = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACC_RANGE  = 3'd0,
    CFG_GYRO_RANGE = 3'd1,
    CFG_MAG_OFF_X  = 3'd2,
    CFG_MAG_OFF_Y  = 3'd3,
    CFG_MAG_OFF_Z  = 3'd4,
    CFG_MAG_GAIN_X = 3'd5,
    CFG_MAG_GAIN_Y = 3'd6,
    CFG_MAG_GAIN_Z = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [WORD_W-1:0] acc_word0;
    logic signed [WORD_W-1:0] acc_word1;
    logic signed [WORD_W-1:0] acc_word2;
    logic signed [WORD_W-1:0] gyro_word0;
    logic signed [WORD_W-1:0] gyro_word1;
    logic signed [WORD_W-1:0] gyro_word2;
    logic signed [WORD_W-1:0] mag_word0;
    logic signed [WORD_W-1:0] mag_word1;
    logic signed [WORD_W-1:0] mag_word2;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] accel_x;
    logic signed [OUT_W-1:0] accel_y;
    logic signed [OUT_W-1:0] accel_z;
    logic signed [OUT_W-1:0] rate_x;
    logic signed [OUT_W-1:0] rate_y;
    logic signed [OUT_W-1:0] rate_z;
    logic signed [OUT_W-1:0] field_x;
    logic signed [OUT_W-1:0] field_y;
    logic signed [OUT_W-1:0] field_z;
  } out_item_t;

  typedef logic [2:0][WORD_W-1:0] vec3_t;

  typedef struct packed {
    logic load;
    logic step;
    logic last;
  } mul_ctrl_t;

  typedef struct packed {
    logic load1;
    logic load2;
    logic step;
    logic last;
  } lane_ctrl_t;

  typedef struct packed {
    logic sample;
    logic finish;
  } cal_ctrl_t;

  function automatic logic [MC_W-1:0] acc_k(input logic [1:0] rng);
    logic [MC_W-1:0] k;
    unique case (rng)
      2'd0:    k = ACC_K0[MC_W-1:0];
      2'd1:    k = ACC_K1[MC_W-1:0];
      2'd2:    k = ACC_K2[MC_W-1:0];
      default: k = ACC_K3[MC_W-1:0];
    endcase
    return k;
  endfunction

  function automatic logic [MC_W-1:0] gyr_k(input logic [1:0] rng);
    logic [MC_W-1:0] k;
    unique case (rng)
      2'd0:    k = GYR_K0[MC_W-1:0];
      2'd1:    k = GYR_K1[MC_W-1:0];
      2'd2:    k = GYR_K2[MC_W-1:0];
      default: k = GYR_K3[MC_W-1:0];
    endcase
    return k;
  endfunction

  // round half up, then clamp to signed 32 bits
  function automatic logic [OUT_W-1:0] round_sat(input logic signed [63:0] p,
                                                 input int unsigned s);
    logic signed [63:0] r;
    logic [OUT_W-1:0]   res;
    r = (p + (64'sd1 <<< (s - 1))) >>> s;
    if (r > SAT_MAX) begin
      res = SAT_MAX[OUT_W-1:0];
    end else if (r < SAT_MIN) begin
      res = SAT_MIN[OUT_W-1:0];
    end else begin
      res = r[OUT_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/imu_raw_to_units_converter_unit.sv
// imu raw-to-units converter
//
// input channel (in_valid_i/in_ready_o/in_data_i): one transaction carries a mode and
// nine raw sensor words. convert mode yields one result transaction on the output
// channel (out_valid_o/out_ready_i/out_data_o): g, rad/s and uT in signed Q15.16.
// calibrate and finish modes update the gyro bias trackers in the accept cycle and
// produce nothing; the unused mode code is dropped.
// a taken convert transaction goes through two bit-serial multiply passes, a reload
// step and a rounding step before it shows up at the output.
// a new convert transaction is taken only once the last one has left the rounding step,
// as set by the serial multipliers, two per axis, each retiring one multiplier bit per
// cycle while busy; calibrate and finish transactions are taken back to back.
// the output register decouples the two sides: a new input is taken while a result
// waits; if the receiver stalls, a finished result waits in the rounding stage until
// the output register frees up.
// configuration writes (cfg_we_i): the user must make them only while idle, unchecked.
// reset: configuration returns to defaults, bias clears, trackers rearm, no output valid.
`default_nettype none

module imu_raw_to_units_converter_unit (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  icv_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output icv_pkg::out_item_t            out_data_o,
  input  wire                           cfg_we_i,
  input  wire [icv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [icv_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import icv_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_LOAD2,
    ST_MUL2,
    ST_FIN
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                out_valid_q;
  out_item_t           out_data_q;

  // configuration registers
  logic [1:0]                 acc_range_q;
  logic [1:0]                 gyro_range_q;
  logic [2:0][OFF_W-1:0]      mag_off_q;
  logic [2:0][GAIN_W-1:0]     mag_gain_q;

  logic        in_fire;
  logic        is_convert;
  logic        step_last;
  logic        fin_take;
  lane_ctrl_t  lctrl;
  cal_ctrl_t   cctrl;

  vec3_t acc_v;
  vec3_t gyr_v;
  vec3_t mag_v;
  vec3_t bias_v;

  logic [2:0][OUT_W-1:0] accel_r;
  logic [2:0][OUT_W-1:0] rate_r;
  logic [2:0][OUT_W-1:0] field_r;

  logic [MC_W-1:0] acc_k_sel;
  logic [MC_W-1:0] gyr_k_sel;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign is_convert = (in_data_i.mode == MODE_CONVERT);
  assign step_last  = (cnt_q == CNT_W'(MUL_W - 1));
  assign fin_take   = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  // axis remap: accel x/y swapped, gyro swapped and negated, mag z negated
  always_comb begin
    acc_v[0] = in_data_i.acc_word1;
    acc_v[1] = in_data_i.acc_word0;
    acc_v[2] = in_data_i.acc_word2;
    gyr_v[0] = -in_data_i.gyro_word1;
    gyr_v[1] = -in_data_i.gyro_word0;
    gyr_v[2] = -in_data_i.gyro_word2;
    mag_v[0] = in_data_i.mag_word0;
    mag_v[1] = in_data_i.mag_word1;
    mag_v[2] = -in_data_i.mag_word2;
  end

  // lane and tracker control
  always_comb begin
    lctrl.load1  = in_fire && is_convert;
    lctrl.load2  = (state_q == ST_LOAD2);
    lctrl.step   = (state_q == ST_MUL1) || (state_q == ST_MUL2);
    lctrl.last   = lctrl.step && step_last;
    cctrl.sample = in_fire && (in_data_i.mode == MODE_SAMPLE);
    cctrl.finish = in_fire && (in_data_i.mode == MODE_FINISH);
  end

  assign acc_k_sel = acc_k(acc_range_q);
  assign gyr_k_sel = gyr_k(gyro_range_q);

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_range_q   <= '0;
      gyro_range_q  <= '0;
      mag_off_q[0]  <= MAG_OFF_X_RST;
      mag_off_q[1]  <= MAG_OFF_Y_RST;
      mag_off_q[2]  <= MAG_OFF_Z_RST;
      mag_gain_q[0] <= MAG_GAIN_X_RST;
      mag_gain_q[1] <= MAG_GAIN_Y_RST;
      mag_gain_q[2] <= MAG_GAIN_Z_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ACC_RANGE:  acc_range_q   <= cfg_wdata_i[1:0];
        CFG_GYRO_RANGE: gyro_range_q  <= cfg_wdata_i[1:0];
        CFG_MAG_OFF_X:  mag_off_q[0]  <= cfg_wdata_i[OFF_W-1:0];
        CFG_MAG_OFF_Y:  mag_off_q[1]  <= cfg_wdata_i[OFF_W-1:0];
        CFG_MAG_OFF_Z:  mag_off_q[2]  <= cfg_wdata_i[OFF_W-1:0];
        CFG_MAG_GAIN_X: mag_gain_q[0] <= cfg_wdata_i[GAIN_W-1:0];
        CFG_MAG_GAIN_Y: mag_gain_q[1] <= cfg_wdata_i[GAIN_W-1:0];
        CFG_MAG_GAIN_Z: mag_gain_q[2] <= cfg_wdata_i[GAIN_W-1:0];
      endcase
    end
  end

  // sequencer: pass one (accel, 0.15*mag), reload, pass two (rate, gain), round
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a finished result fills the output register, a taken one frees it
      if (fin_take) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && is_convert) begin
            state_q <= ST_MUL1;
            cnt_q   <= '0;
          end
        end
        ST_MUL1: begin
          if (step_last) begin
            state_q <= ST_LOAD2;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_LOAD2: begin
          state_q <= ST_MUL2;
        end
        ST_MUL2: begin
          if (step_last) begin
            state_q <= ST_FIN;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_FIN: begin
          // wait here while the output register still holds an untaken result
          if (fin_take) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (fin_take) begin
      out_data_q.accel_x <= accel_r[0];
      out_data_q.accel_y <= accel_r[1];
      out_data_q.accel_z <= accel_r[2];
      out_data_q.rate_x  <= rate_r[0];
      out_data_q.rate_y  <= rate_r[1];
      out_data_q.rate_z  <= rate_r[2];
      out_data_q.field_x <= field_r[0];
      out_data_q.field_y <= field_r[1];
      out_data_q.field_z <= field_r[2];
    end
  end

  icv_cal u_cal (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(cctrl),
    .gyro_i(gyr_v),
    .bias_o(bias_v)
  );

  // one lane per axis, x y z
  for (genvar a = 0; a < 3; a++) begin : g_lane
    icv_lane u_lane (
      .clk_i   (clk_i),
      .ctrl_i  (lctrl),
      .acc_i   (acc_v[a]),
      .gyro_i  (gyr_v[a]),
      .bias_i  (bias_v[a]),
      .mag_i   (mag_v[a]),
      .acc_k_i (acc_k_sel),
      .gyr_k_i (gyr_k_sel),
      .offset_i(mag_off_q[a]),
      .gain_i  (mag_gain_q[a]),
      .accel_o (accel_r[a]),
      .rate_o  (rate_r[a]),
      .field_o (field_r[a])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: rtl/core/icv_smul.sv
`default_nettype none

// serial-parallel signed multiplier, multiplier bits taken lsb first
module icv_smul (
  input  wire                      clk_i,
  input  icv_pkg::mul_ctrl_t       ctrl_i,
  input  wire [icv_pkg::MC_W-1:0]  mcand_i,
  input  wire [icv_pkg::MUL_W-1:0] mplier_i,
  output logic [icv_pkg::PROD_W-1:0] prod_o
);
  import icv_pkg::*;

  logic [MC_W-1:0]         mc_q;
  logic [MUL_W-1:0]        mp_q;
  logic signed [MC_W:0]    hi_q;
  logic [MUL_W-1:0]        lo_q;
  logic signed [MC_W+1:0]  mc_ext;
  logic signed [MC_W+1:0]  pp;
  logic signed [MC_W+1:0]  sum;

  always_comb begin
    mc_ext = $signed({{2{mc_q[MC_W-1]}}, mc_q});
    if (!mp_q[0]) begin
      pp = '0;
    end else if (ctrl_i.last) begin
      pp = -mc_ext;   // sign bit carries negative weight
    end else begin
      pp = mc_ext;
    end
    sum = $signed({hi_q[MC_W], hi_q}) + pp;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mc_q <= mcand_i;
      mp_q <= mplier_i;
      hi_q <= '0;
      lo_q <= '0;
    end else if (ctrl_i.step) begin
      hi_q <= sum[MC_W+1:1];
      lo_q <= {sum[0], lo_q[MUL_W-1:1]};
      mp_q <= {1'b0, mp_q[MUL_W-1:1]};
    end
  end

  assign prod_o = {hi_q, lo_q};

endmodule

`default_nettype wire

FILE: rtl/core/icv_lane.sv
`default_nettype none

// one axis: accel then rate on unit a, magnetometer two-step product on unit b
module icv_lane (
  input  wire                       clk_i,
  input  icv_pkg::lane_ctrl_t       ctrl_i,
  input  wire [icv_pkg::WORD_W-1:0] acc_i,
  input  wire [icv_pkg::WORD_W-1:0] gyro_i,
  input  wire [icv_pkg::WORD_W-1:0] bias_i,
  input  wire [icv_pkg::WORD_W-1:0] mag_i,
  input  wire [icv_pkg::MC_W-1:0]   acc_k_i,
  input  wire [icv_pkg::MC_W-1:0]   gyr_k_i,
  input  wire [icv_pkg::OFF_W-1:0]  offset_i,
  input  wire [icv_pkg::GAIN_W-1:0] gain_i,
  output logic [icv_pkg::OUT_W-1:0] accel_o,
  output logic [icv_pkg::OUT_W-1:0] rate_o,
  output logic [icv_pkg::OUT_W-1:0] field_o
);
  import icv_pkg::*;

  mul_ctrl_t          mctrl;
  logic [MC_W-1:0]    a_mcand;
  logic [MUL_W-1:0]   a_mplier;
  logic [MC_W-1:0]    b_mcand;
  logic [MUL_W-1:0]   b_mplier;
  logic [PROD_W-1:0]  a_prod;
  logic [PROD_W-1:0]  b_prod;
  logic [MC_W-1:0]    off_ext;
  logic [MC_W-1:0]    mag_mc2;
  logic [MUL_W-1:0]   rate_op_q;
  logic [63:0]        acc_prod_q;

  always_comb begin
    mctrl.load = ctrl_i.load1 | ctrl_i.load2;
    mctrl.step = ctrl_i.step;
    mctrl.last = ctrl_i.last;

    // offset scaled by 2^32, subtracted from 0.15 * raw
    off_ext = {{(MC_W - OFF_W - 32){offset_i[OFF_W-1]}}, offset_i, 32'b0};
    mag_mc2 = b_prod[MC_W-1:0] - off_ext;

    a_mcand  = ctrl_i.load2 ? gyr_k_i : acc_k_i;
    a_mplier = ctrl_i.load2 ? rate_op_q : {acc_i[WORD_W-1], acc_i};
    b_mcand  = ctrl_i.load2 ? mag_mc2 : MAG_K15[MC_W-1:0];
    b_mplier = ctrl_i.load2 ? {1'b0, gain_i} : {mag_i[WORD_W-1], mag_i};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load1) begin
      rate_op_q <= {gyro_i[WORD_W-1], gyro_i} - {bias_i[WORD_W-1], bias_i};
    end
    if (ctrl_i.load2) begin
      acc_prod_q <= a_prod[63:0];
    end
  end

  icv_smul u_mul_a (
    .clk_i   (clk_i),
    .ctrl_i  (mctrl),
    .mcand_i (a_mcand),
    .mplier_i(a_mplier),
    .prod_o  (a_prod)
  );

  icv_smul u_mul_b (
    .clk_i   (clk_i),
    .ctrl_i  (mctrl),
    .mcand_i (b_mcand),
    .mplier_i(b_mplier),
    .prod_o  (b_prod)
  );

  assign accel_o = round_sat($signed(acc_prod_q), SH_ACC);
  assign rate_o  = round_sat($signed(a_prod[63:0]), SH_ACC);
  assign field_o = round_sat($signed(b_prod[63:0]), SH_MAG);

endmodule

`default_nettype wire

FILE: rtl/core/icv_cal.sv
`default_nettype none

// gyro min/max trackers and bias
module icv_cal (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  icv_pkg::cal_ctrl_t  ctrl_i,
  input  icv_pkg::vec3_t      gyro_i,
  output icv_pkg::vec3_t      bias_o
);
  import icv_pkg::*;

  vec3_t max_q;
  vec3_t min_q;
  vec3_t bias_q;
  vec3_t mid;

  logic signed [WORD_W:0] sum [3];
  logic signed [WORD_W:0] adj [3];

  // midpoint truncated toward zero: add one before halving a negative sum
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = $signed({max_q[i][WORD_W-1], max_q[i]}) +
               $signed({min_q[i][WORD_W-1], min_q[i]});
      adj[i] = sum[i] + $signed({{WORD_W{1'b0}}, sum[i][WORD_W]});
      mid[i] = adj[i][WORD_W:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        max_q[i]  <= CAL_MAX_RST;
        min_q[i]  <= CAL_MIN_RST;
        bias_q[i] <= '0;
      end
    end else if (ctrl_i.finish) begin
      for (int i = 0; i < 3; i++) begin
        bias_q[i] <= mid[i];
        max_q[i]  <= CAL_MAX_RST;
        min_q[i]  <= CAL_MIN_RST;
      end
    end else if (ctrl_i.sample) begin
      for (int i = 0; i < 3; i++) begin
        if ($signed(gyro_i[i]) > $signed(max_q[i])) begin
          max_q[i] <= gyro_i[i];
        end
        if ($signed(gyro_i[i]) < $signed(min_q[i])) begin
          min_q[i] <= gyro_i[i];
        end
      end
    end
  end

  assign bias_o = bias_q;

endmodule

`default_nettype wire

FILE: rtl/core/icv_chk.sv
`default_nettype none

// port-level checks for the converter
module icv_chk (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           in_valid_i,
  input wire                           in_ready_o,
  input icv_pkg::in_item_t             in_data_i,
  input wire                           out_valid_o,
  input wire                           out_ready_i,
  input icv_pkg::out_item_t            out_data_o,
  input wire                           cfg_we_i,
  input wire [icv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input wire [icv_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import icv_pkg::*;

  logic in_fire;
  logic conv_fire;
  logic cfg_seen;

  assign in_fire   = in_valid_i && in_ready_o;
  assign conv_fire = in_fire && (in_data_i.mode == MODE_CONVERT);
  assign cfg_seen  = cfg_we_i && (cfg_idx_i == cfg_idx_i) && (cfg_wdata_i == cfg_wdata_i);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  // a convert transaction occupies the multipliers
  a_busy_after_convert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_fire |=> !in_ready_o)
    else $error("input taken while a conversion is in flight");

  a_busy_full_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_fire |-> ##36 !in_ready_o)
    else $error("conversion finished early");

  // calibrate, finish and unused-mode transactions keep the input open when no configuration write comes with them
  a_cal_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_data_i.mode != MODE_CONVERT) && !cfg_seen |=> in_ready_o)
    else $error("non-convert transaction stalled the input");

  // a new result only comes out of a busy period
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a conversion");

endmodule

bind imu_raw_to_units_converter_unit icv_chk u_icv_chk (.*);

`default_nettype wire

FILE: verif/imu_units_checker.sv
module imu_units_checker import icv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  input  logic      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [8:0][OUT_W-1:0] units_words_t;

  localparam longint TWO_POW32 = 64'sd4294967296;
  localparam longint PI_FIX    = 64'sd13493037705;
  localparam int unsigned ACC_SHIFT = 16;
  localparam int unsigned MAG_SHIFT = 30;

  // per-lsb scale factors times 2^32, rounded to nearest
  localparam longint ACC_2G  = (64'd610 * TWO_POW32 + 64'd5000000) / 64'd10000000;
  localparam longint ACC_4G  = (64'd12207 * TWO_POW32 + 64'd50000000) / 64'd100000000;
  localparam longint ACC_8G  = (64'd2441 * TWO_POW32 + 64'd5000000) / 64'd10000000;
  localparam longint ACC_16G = (64'd48828 * TWO_POW32 + 64'd50000000) / 64'd100000000;
  localparam longint GYR_250  = (64'd763 * PI_FIX + 64'd9000000) / 64'd18000000;
  localparam longint GYR_500  = (64'd1527 * PI_FIX + 64'd9000000) / 64'd18000000;
  localparam longint GYR_1000 = (64'd3049 * PI_FIX + 64'd9000000) / 64'd18000000;
  localparam longint GYR_2000 = (64'd6097 * PI_FIX + 64'd9000000) / 64'd18000000;
  localparam longint MAG_LSB  = (64'd15 * TWO_POW32 + 64'd50) / 64'd100;

  logic [1:0]        acc_rng, gyro_rng;
  logic signed [9:0] mag_off [3];
  logic [15:0]       mag_gain [3];
  logic signed [15:0] bias [3];
  logic signed [15:0] trk_max [3];
  logic signed [15:0] trk_min [3];

  out_item_t    units_due [$];
  out_item_t    want;
  units_words_t got_w, want_w;
  int           fails = 0;

  function automatic longint acc_scale(input logic [1:0] rng);
    case (rng)
      2'd0:    return ACC_2G;
      2'd1:    return ACC_4G;
      2'd2:    return ACC_8G;
      default: return ACC_16G;
    endcase
  endfunction

  function automatic longint gyro_scale(input logic [1:0] rng);
    case (rng)
      2'd0:    return GYR_250;
      2'd1:    return GYR_500;
      2'd2:    return GYR_1000;
      default: return GYR_2000;
    endcase
  endfunction

  // round half up, clamp to 32 bits signed
  function automatic logic signed [31:0] round_clamp(input longint p, input int unsigned s);
    longint r;
    r = (p + (longint'(1) <<< (s - 1))) >>> s;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  // remapped gyro axis, negation wraps at 16 bits
  function automatic logic signed [15:0] gyro_axis(input in_item_t f, input int i);
    logic signed [15:0] w;
    case (i)
      0:       w = f.gyro_word1;
      1:       w = f.gyro_word0;
      default: w = f.gyro_word2;
    endcase
    return -w;
  endfunction

  function automatic out_item_t scale_frame(input in_item_t f);
    logic signed [15:0] a [3];
    logic signed [15:0] mg [3];
    logic signed [31:0] ac [3];
    logic signed [31:0] rt [3];
    logic signed [31:0] fd [3];
    longint ka, kg, m;
    out_item_t r;
    a[0] = f.acc_word1;
    a[1] = f.acc_word0;
    a[2] = f.acc_word2;
    mg[0] = f.mag_word0;
    mg[1] = f.mag_word1;
    mg[2] = -f.mag_word2;
    ka = acc_scale(acc_rng);
    kg = gyro_scale(gyro_rng);
    for (int i = 0; i < 3; i++) begin
      ac[i] = round_clamp(longint'(a[i]) * ka, ACC_SHIFT);
      rt[i] = round_clamp((longint'(gyro_axis(f, i)) - longint'(bias[i])) * kg, ACC_SHIFT);
      m = longint'(mg[i]) * MAG_LSB - longint'(mag_off[i]) * TWO_POW32;
      fd[i] = round_clamp(m * longint'(mag_gain[i]), MAG_SHIFT);
    end
    r.accel_x = ac[0];
    r.accel_y = ac[1];
    r.accel_z = ac[2];
    r.rate_x  = rt[0];
    r.rate_y  = rt[1];
    r.rate_z  = rt[2];
    r.field_x = fd[0];
    r.field_y = fd[1];
    r.field_z = fd[2];
    return r;
  endfunction

  function automatic string field_label(input int i);
    case (i)
      0:       return "accel_x";
      1:       return "accel_y";
      2:       return "accel_z";
      3:       return "rate_x";
      4:       return "rate_y";
      5:       return "rate_z";
      6:       return "field_x";
      7:       return "field_y";
      default: return "field_z";
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_rng  = 2'd0;
      gyro_rng = 2'd0;
      mag_off  = '{10'sd26, 10'sd14, 10'sd35};
      mag_gain = '{16'd18907, 16'd19169, 16'd18022};
      for (int i = 0; i < 3; i++) begin
        bias[i]    = 16'sd0;
        trk_max[i] = 16'sh8000;
        trk_min[i] = 16'sh7fff;
      end
      units_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (units_due.size() == 0) begin
          $error("result transaction with nothing outstanding: %h", out_data_i);
          fails++;
        end else begin
          want   = units_due.pop_front();
          got_w  = units_words_t'(out_data_i);
          want_w = units_words_t'(want);
          for (int i = 0; i < 9; i++) begin
            if (got_w[8-i] !== want_w[8-i]) begin
              $error("%s expected %0d actual %0d", field_label(i),
                     $signed(want_w[8-i]), $signed(got_w[8-i]));
              fails++;
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ACC_RANGE:  acc_rng     = cfg_wdata_i[1:0];
          CFG_GYRO_RANGE: gyro_rng    = cfg_wdata_i[1:0];
          CFG_MAG_OFF_X:  mag_off[0]  = cfg_wdata_i[9:0];
          CFG_MAG_OFF_Y:  mag_off[1]  = cfg_wdata_i[9:0];
          CFG_MAG_OFF_Z:  mag_off[2]  = cfg_wdata_i[9:0];
          CFG_MAG_GAIN_X: mag_gain[0] = cfg_wdata_i;
          CFG_MAG_GAIN_Y: mag_gain[1] = cfg_wdata_i;
          CFG_MAG_GAIN_Z: mag_gain[2] = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        case (in_data_i.mode)
          MODE_CONVERT: units_due.push_back(scale_frame(in_data_i));
          MODE_SAMPLE: begin
            for (int i = 0; i < 3; i++) begin
              if (gyro_axis(in_data_i, i) > trk_max[i]) trk_max[i] = gyro_axis(in_data_i, i);
              if (gyro_axis(in_data_i, i) < trk_min[i]) trk_min[i] = gyro_axis(in_data_i, i);
            end
          end
          MODE_FINISH: begin
            // midpoint truncates toward zero
            for (int i = 0; i < 3; i++) begin
              bias[i]    = 16'((int'(trk_max[i]) + int'(trk_min[i])) / 2);
              trk_max[i] = 16'sh8000;
              trk_min[i] = 16'sh7fff;
            end
          end
          default: ;
        endcase
      end
    end
    pending_o    <= units_due.size();
    fail_count_o <= fails;
  end

endmodule

FILE: verif/tb_top.sv
module tb_top import icv_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // mode code the block drops without effect
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // cycles to let the pipeline settle once nothing is outstanding
  localparam int SETTLE_CYCLES = 45;
  // long receiver hold-off, enough to back the block up into its input
  localparam int HOLD_CYCLES = 400;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int        fail_count;
  int        pending;

  // idle percentages of the two sides, changed per phase
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  bit hold_req = 1'b0;

  imu_raw_to_units_converter_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  imu_units_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver side: random stalls, plus a long hold-off when requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // uniform words half the time, with extremes and small values mixed in
  function automatic logic [15:0] pick_word();
    case ($urandom_range(11))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      4:       return 16'h0001;
      5:       return 16'($urandom_range(64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t pick_frame(input logic [1:0] m);
    in_item_t f;
    f.mode       = m;
    f.acc_word0  = pick_word();
    f.acc_word1  = pick_word();
    f.acc_word2  = pick_word();
    f.gyro_word0 = pick_word();
    f.gyro_word1 = pick_word();
    f.gyro_word2 = pick_word();
    f.mag_word0  = pick_word();
    f.mag_word1  = pick_word();
    f.mag_word2  = pick_word();
    return f;
  endfunction

  // same word on all nine sensor fields
  function automatic in_item_t flat_frame(input logic [1:0] m, input logic [15:0] w);
    in_item_t f;
    f = {m, {9{w}}};
    return f;
  endfunction

  // offer one transaction, called at a falling edge, returns at the falling edge after
  // the accept; valid stays up between back-to-back transactions
  task automatic send_frame(input in_item_t f);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data  = f;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // sender pauses until every expected result is back, then the pipeline settles
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] v);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = v;
    @(negedge clk);
  endtask

  // unused upper bits get random content, the block must ignore them
  task automatic program_regs(input logic [1:0] ar, input logic [1:0] gr,
                              input logic [9:0] ox, input logic [9:0] oy,
                              input logic [9:0] oz, input logic [15:0] gx,
                              input logic [15:0] gy, input logic [15:0] gz);
    write_reg(CFG_ACC_RANGE,  {14'($urandom), ar});
    write_reg(CFG_GYRO_RANGE, {14'($urandom), gr});
    write_reg(CFG_MAG_OFF_X,  {6'($urandom), ox});
    write_reg(CFG_MAG_OFF_Y,  {6'($urandom), oy});
    write_reg(CFG_MAG_OFF_Z,  {6'($urandom), oz});
    write_reg(CFG_MAG_GAIN_X, gx);
    write_reg(CFG_MAG_GAIN_Y, gy);
    write_reg(CFG_MAG_GAIN_Z, gz);
    cfg_we = 1'b0;
  endtask

  task automatic program_random();
    program_regs(2'($urandom), 2'($urandom), 10'($urandom), 10'($urandom),
                 10'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // calibration episodes followed by convert bursts, with dropped-mode noise,
  // finish without samples and samples left pending across episodes
  task automatic run_phase(input int n_items, input bit with_pressure);
    int  sent;
    int  k;
    bit  pressed;
    sent    = 0;
    pressed = 1'b0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 8) begin
        send_frame(pick_frame(MODE_UNUSED));
      end
      if ($urandom_range(99) < 70) begin
        k = $urandom_range(6);
        repeat (k) send_frame(pick_frame(MODE_SAMPLE));
        sent += k;
        // some episodes leave the trackers armed into the next one
        if ($urandom_range(99) < 80) begin
          send_frame(pick_frame(MODE_FINISH));
          sent++;
        end
      end
      k = $urandom_range(1, 8);
      repeat (k) send_frame(pick_frame(MODE_CONVERT));
      sent += k;
      if (with_pressure && !pressed && sent > n_items / 3) begin
        // receiver holds off while converts keep coming, input must back up
        hold_req = 1'b1;
        repeat (12) send_frame(pick_frame(MODE_CONVERT));
        sent += 12;
        drain_results();
        pressed = 1'b1;
      end
    end
  endtask

  // run limit, far above the slowest legal run
  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed part at reset configuration
    send_frame(flat_frame(MODE_CONVERT, 16'h0000));
    send_frame(flat_frame(MODE_CONVERT, 16'h7fff));
    send_frame(flat_frame(MODE_CONVERT, 16'h8000));  // negation wraps
    send_frame(flat_frame(MODE_CONVERT, 16'hffff));
    send_frame(flat_frame(MODE_FINISH, 16'h1234));   // finish with no samples, bias 0
    send_frame(flat_frame(MODE_CONVERT, 16'h8000));
    send_frame(flat_frame(MODE_SAMPLE, 16'h8000));
    send_frame(flat_frame(MODE_SAMPLE, 16'h7fff));
    send_frame(flat_frame(MODE_UNUSED, 16'h0001));   // dropped, trackers untouched
    send_frame(flat_frame(MODE_FINISH, 16'h0000));   // odd negative sum truncates up
    send_frame(flat_frame(MODE_CONVERT, 16'h7fff));
    send_frame(flat_frame(MODE_CONVERT, 16'h8000));
    send_frame(flat_frame(MODE_SAMPLE, 16'h0002));
    send_frame(flat_frame(MODE_SAMPLE, 16'h0001));
    send_frame(flat_frame(MODE_FINISH, 16'h0000));   // midpoint of -1 and -2
    send_frame(flat_frame(MODE_CONVERT, 16'h8001));
    send_frame(flat_frame(MODE_UNUSED, 16'hffff));
    send_frame(pick_frame(MODE_CONVERT));
    drain_results();

    // directed part at the top range settings, with extreme offsets and gains
    program_regs(2'd3, 2'd3, 10'h200, 10'h200, 10'h200, 16'hffff, 16'hffff, 16'hffff);
    send_frame(flat_frame(MODE_CONVERT, 16'h7fff));
    send_frame(flat_frame(MODE_CONVERT, 16'h8000));
    send_frame(flat_frame(MODE_SAMPLE, 16'h7fff));
    send_frame(flat_frame(MODE_FINISH, 16'h0000));
    send_frame(flat_frame(MODE_CONVERT, 16'h8000));
    send_frame(flat_frame(MODE_CONVERT, 16'h8001));  // widest gyro minus bias
    drain_results();

    // phase: no idling on either side, long receiver hold-off inside
    program_regs(2'd1, 2'd2, 10'h1ff, 10'h3ff, 10'h000, 16'h0000, 16'h0001, 16'h8000);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    run_phase(420, 1'b1);
    drain_results();

    // phase: sender mostly idle, low end of the ranges
    program_regs(2'd0, 2'd0, 10'h1ff, 10'h200, 10'h1ff, 16'hffff, 16'h0000, 16'($urandom));
    src_idle_pct   = 67;
    sink_stall_pct = 0;
    run_phase(410, 1'b0);
    drain_results();

    // phase: receiver mostly stalling
    program_random();
    src_idle_pct   = 0;
    sink_stall_pct = 67;
    run_phase(410, 1'b0);
    drain_results();

    // phase: both sides idle now and then
    program_random();
    src_idle_pct   = 16;
    sink_stall_pct = 16;
    run_phase(410, 1'b0);
    drain_results();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/icv_pkg.sv
rtl/core/icv_smul.sv
rtl/core/icv_lane.sv
rtl/core/icv_cal.sv
rtl/core/imu_raw_to_units_converter_unit.sv
rtl/core/icv_chk.sv
verif/imu_units_checker.sv
verif/tb_top.sv
